>>> hdl/mer_pkg.sv
// shared types, widths and codes of the midpoint ellipse rasterizer
package mer_pkg;

    localparam int COORD_BITS = 12;
    localparam int OP_BITS    = 1;
    localparam int OUT_W      = 14;
    localparam int SQ_W       = 2 * COORD_BITS;
    localparam int SLOPE_W    = 3 * COORD_BITS + 4;
    localparam int DEC_W      = 64;
    localparam int MUL_W      = 2 * COORD_BITS + 2;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int SUM_W      = (COORD_BITS + 1 > OUT_W) ? COORD_BITS + 1 : OUT_W;

    localparam logic [OP_BITS-1:0] OP_START = 1'b0;
    localparam logic [OP_BITS-1:0] OP_STEP  = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_REG1,
        PH_REG2,
        PH_DONE
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_RX,
        ST_SQ_RY,
        ST_INIT_MUL,
        ST_INIT_WR,
        ST_TX_SQ,
        ST_RY2_T,
        ST_TY_SQ,
        ST_RX2_U,
        ST_RX2_RY2,
        ST_DEC_FIX,
        ST_R1_STEP,
        ST_R2_STEP,
        ST_DEC_UPD,
        ST_EMIT
    } ctl_state_t;

    // operand pairs of the shared multiplier
    typedef enum logic [2:0] {
        MUL_RXRX,
        MUL_RYRY,
        MUL_RX2RY,
        MUL_TXTX,
        MUL_RY2P,
        MUL_TYTY,
        MUL_RX2P,
        MUL_RX2RY2
    } mul_sel_t;

    // what the registered product is written into
    typedef enum logic [2:0] {
        WR_NONE,
        WR_RX2,
        WR_RY2,
        WR_INIT,
        WR_DEC_SET,
        WR_DEC_ADD4,
        WR_DEC_SUB4
    } wr_sel_t;

    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        wr_sel_t  wr_sel;
        logic     r1_move;
        logic     r2_move;
        logic     dec_upd;
        logic     emit;
        logic     emit_points;
        logic     emit_done;
    } dp_cmd_t;

    typedef struct packed {
        logic y_zero;
        logic sx_lt_sy;
        logic dec_neg;
        logic dec_pos;
    } dp_status_t;

endpackage

>>> hdl/mer_dp.sv
// datapath: ellipse state, shared multiplier, decision update and result register
module mer_dp (
    input  logic                                 aclk,
    input  mer_pkg::dp_cmd_t                     cmd,
    output mer_pkg::dp_status_t                  status,
    input  logic [mer_pkg::COORD_BITS-1:0]       in_center_x,
    input  logic [mer_pkg::COORD_BITS-1:0]       in_center_y,
    input  logic [mer_pkg::COORD_BITS-1:0]       in_radius_x,
    input  logic [mer_pkg::COORD_BITS-1:0]       in_radius_y,
    output logic signed [mer_pkg::OUT_W-1:0]     out_right_x,
    output logic signed [mer_pkg::OUT_W-1:0]     out_left_x,
    output logic signed [mer_pkg::OUT_W-1:0]     out_lower_y,
    output logic signed [mer_pkg::OUT_W-1:0]     out_upper_y,
    output logic                                 out_points_valid,
    output logic                                 out_done_res
);

    logic [mer_pkg::COORD_BITS-1:0] cx_reg, cy_reg, rx_reg, ry_reg;
    logic [mer_pkg::COORD_BITS-1:0] x_reg, x_next, y_reg, y_next;
    logic [mer_pkg::SQ_W-1:0]       rx2_reg, rx2_next, ry2_reg, ry2_next;
    logic [mer_pkg::SLOPE_W-1:0]    sx_reg, sx_next, sy_reg, sy_next;
    logic [mer_pkg::DEC_W-1:0]      dec_reg, dec_next;
    logic [mer_pkg::PROD_W-1:0]     prod_reg, prod_next;
    logic                           diag_reg, diag_next;
    logic                           r2_reg, r2_next;

    logic [mer_pkg::MUL_W-1:0]      mul_a, mul_b;
    logic [mer_pkg::COORD_BITS:0]   tx;
    logic [mer_pkg::COORD_BITS-1:0] ty;
    logic [mer_pkg::DEC_W-1:0]      prod_ext;
    logic [mer_pkg::DEC_W-1:0]      step_inc;
    logic [mer_pkg::DEC_W-1:0]      base_term, sx_term, sy_term;

    logic [mer_pkg::SUM_W-1:0]      sum_rx, sum_lx, sum_ly, sum_uy;
    logic signed [mer_pkg::OUT_W-1:0] rx_out_reg, lx_out_reg, ly_out_reg, uy_out_reg;
    logic                           pv_reg, dn_reg;

    assign tx       = {x_reg, 1'b1};
    assign ty       = y_reg - 1'b1;
    assign prod_ext = mer_pkg::DEC_W'(prod_reg);

    // shared multiplier, product registered every cycle
    always_comb begin
        unique case (cmd.mul_sel)
            mer_pkg::MUL_RXRX: begin
                mul_a = mer_pkg::MUL_W'(rx_reg);
                mul_b = mer_pkg::MUL_W'(rx_reg);
            end
            mer_pkg::MUL_RYRY: begin
                mul_a = mer_pkg::MUL_W'(ry_reg);
                mul_b = mer_pkg::MUL_W'(ry_reg);
            end
            mer_pkg::MUL_RX2RY: begin
                mul_a = mer_pkg::MUL_W'(rx2_reg);
                mul_b = mer_pkg::MUL_W'(ry_reg);
            end
            mer_pkg::MUL_TXTX: begin
                mul_a = mer_pkg::MUL_W'(tx);
                mul_b = mer_pkg::MUL_W'(tx);
            end
            mer_pkg::MUL_RY2P: begin
                mul_a = mer_pkg::MUL_W'(ry2_reg);
                mul_b = prod_reg[mer_pkg::MUL_W-1:0];
            end
            mer_pkg::MUL_TYTY: begin
                mul_a = mer_pkg::MUL_W'(ty);
                mul_b = mer_pkg::MUL_W'(ty);
            end
            mer_pkg::MUL_RX2P: begin
                mul_a = mer_pkg::MUL_W'(rx2_reg);
                mul_b = prod_reg[mer_pkg::MUL_W-1:0];
            end
            mer_pkg::MUL_RX2RY2: begin
                mul_a = mer_pkg::MUL_W'(rx2_reg);
                mul_b = mer_pkg::MUL_W'(ry2_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // decision increment after a move, using the already moved slope terms
    always_comb begin
        base_term = r2_reg ? mer_pkg::DEC_W'(rx2_reg) : mer_pkg::DEC_W'(ry2_reg);
        sx_term   = (!r2_reg || diag_reg) ? mer_pkg::DEC_W'(sx_reg) : '0;
        sy_term   = (r2_reg || diag_reg) ? mer_pkg::DEC_W'(sy_reg) : '0;
        step_inc  = base_term + sx_term - sy_term;
    end

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        rx2_next  = rx2_reg;
        ry2_next  = ry2_reg;
        sx_next   = sx_reg;
        sy_next   = sy_reg;
        dec_next  = dec_reg;
        diag_next = diag_reg;
        r2_next   = r2_reg;

        if (cmd.load) begin
            x_next  = '0;
            y_next  = in_radius_y;
            sx_next = '0;
        end

        unique case (cmd.wr_sel)
            mer_pkg::WR_NONE: ;
            mer_pkg::WR_RX2: rx2_next = prod_reg[mer_pkg::SQ_W-1:0];
            mer_pkg::WR_RY2: ry2_next = prod_reg[mer_pkg::SQ_W-1:0];
            mer_pkg::WR_INIT: begin
                sy_next  = {prod_reg[mer_pkg::SLOPE_W-2:0], 1'b0};
                dec_next = (mer_pkg::DEC_W'(ry2_reg) << 2) - (prod_ext << 2)
                         + mer_pkg::DEC_W'(rx2_reg);
            end
            mer_pkg::WR_DEC_SET:  dec_next = prod_ext;
            mer_pkg::WR_DEC_ADD4: dec_next = dec_reg + (prod_ext << 2);
            mer_pkg::WR_DEC_SUB4: dec_next = dec_reg - (prod_ext << 2);
            default: ;
        endcase

        if (cmd.r1_move) begin
            r2_next   = 1'b0;
            x_next    = x_reg + 1'b1;
            sx_next   = sx_reg + mer_pkg::SLOPE_W'({ry2_reg, 1'b0});
            diag_next = !status.dec_neg;
            if (!status.dec_neg) begin
                y_next  = y_reg - 1'b1;
                sy_next = sy_reg - mer_pkg::SLOPE_W'({rx2_reg, 1'b0});
            end
        end

        if (cmd.r2_move) begin
            r2_next   = 1'b1;
            y_next    = y_reg - 1'b1;
            sy_next   = sy_reg - mer_pkg::SLOPE_W'({rx2_reg, 1'b0});
            diag_next = !status.dec_pos;
            if (!status.dec_pos) begin
                x_next  = x_reg + 1'b1;
                sx_next = sx_reg + mer_pkg::SLOPE_W'({ry2_reg, 1'b0});
            end
        end

        if (cmd.dec_upd) begin
            dec_next = dec_reg + (step_inc << 2);
        end
    end

    assign status.y_zero   = (y_reg == '0);
    assign status.sx_lt_sy = (sx_reg < sy_reg);
    assign status.dec_neg  = dec_reg[mer_pkg::DEC_W-1];
    assign status.dec_pos  = (dec_reg != '0) && !dec_reg[mer_pkg::DEC_W-1];

    assign sum_rx = mer_pkg::SUM_W'(cx_reg) + mer_pkg::SUM_W'(x_reg);
    assign sum_lx = mer_pkg::SUM_W'(cx_reg) - mer_pkg::SUM_W'(x_reg);
    assign sum_ly = mer_pkg::SUM_W'(cy_reg) + mer_pkg::SUM_W'(y_reg);
    assign sum_uy = mer_pkg::SUM_W'(cy_reg) - mer_pkg::SUM_W'(y_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cx_reg <= in_center_x;
            cy_reg <= in_center_y;
            rx_reg <= in_radius_x;
            ry_reg <= in_radius_y;
        end
        x_reg    <= x_next;
        y_reg    <= y_next;
        rx2_reg  <= rx2_next;
        ry2_reg  <= ry2_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        dec_reg  <= dec_next;
        diag_reg <= diag_next;
        r2_reg   <= r2_next;
        prod_reg <= prod_next;
        if (cmd.emit) begin
            if (cmd.emit_points) begin
                rx_out_reg <= sum_rx[mer_pkg::OUT_W-1:0];
                lx_out_reg <= sum_lx[mer_pkg::OUT_W-1:0];
                ly_out_reg <= sum_ly[mer_pkg::OUT_W-1:0];
                uy_out_reg <= sum_uy[mer_pkg::OUT_W-1:0];
                dn_reg     <= status.y_zero;
            end else begin
                rx_out_reg <= '0;
                lx_out_reg <= '0;
                ly_out_reg <= '0;
                uy_out_reg <= '0;
                dn_reg     <= cmd.emit_done;
            end
            pv_reg <= cmd.emit_points;
        end
    end

    assign out_right_x      = rx_out_reg;
    assign out_left_x       = lx_out_reg;
    assign out_lower_y      = ly_out_reg;
    assign out_upper_y      = uy_out_reg;
    assign out_points_valid = pv_reg;
    assign out_done_res     = dn_reg;

endmodule

>>> hdl/mer_ctrl.sv
// controller: sequencing state machine, ellipse phase and result handshake
module mer_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mer_pkg::OP_BITS-1:0]       s_op,
    output logic                              m_valid,
    input  logic                              m_ready,
    output mer_pkg::dp_cmd_t                  cmd,
    input  mer_pkg::dp_status_t               status
);

    mer_pkg::ctl_state_t state_reg, state_next;
    mer_pkg::phase_t     phase_reg, phase_next;
    logic                pts_reg, pts_next;
    logic                m_valid_reg, m_valid_next;
    logic                accept;
    logic                can_emit;

    assign s_ready  = (state_reg == mer_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign can_emit = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mer_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_op == mer_pkg::OP_START) begin
                        state_next = mer_pkg::ST_SQ_RX;
                    end else begin
                        unique case (phase_reg)
                            mer_pkg::PH_REG1: state_next = status.sx_lt_sy ?
                                mer_pkg::ST_R1_STEP : mer_pkg::ST_TX_SQ;
                            mer_pkg::PH_REG2: state_next = mer_pkg::ST_R2_STEP;
                            default:          state_next = mer_pkg::ST_EMIT;
                        endcase
                    end
                end
            end
            mer_pkg::ST_SQ_RX:    state_next = mer_pkg::ST_SQ_RY;
            mer_pkg::ST_SQ_RY:    state_next = mer_pkg::ST_INIT_MUL;
            mer_pkg::ST_INIT_MUL: state_next = mer_pkg::ST_INIT_WR;
            mer_pkg::ST_INIT_WR:  state_next = mer_pkg::ST_EMIT;
            mer_pkg::ST_TX_SQ:    state_next = mer_pkg::ST_RY2_T;
            mer_pkg::ST_RY2_T:    state_next = mer_pkg::ST_TY_SQ;
            mer_pkg::ST_TY_SQ:    state_next = mer_pkg::ST_RX2_U;
            mer_pkg::ST_RX2_U:    state_next = mer_pkg::ST_RX2_RY2;
            mer_pkg::ST_RX2_RY2:  state_next = mer_pkg::ST_DEC_FIX;
            mer_pkg::ST_DEC_FIX:  state_next = mer_pkg::ST_R2_STEP;
            mer_pkg::ST_R1_STEP:  state_next = mer_pkg::ST_DEC_UPD;
            mer_pkg::ST_R2_STEP:  state_next = mer_pkg::ST_DEC_UPD;
            mer_pkg::ST_DEC_UPD:  state_next = mer_pkg::ST_EMIT;
            mer_pkg::ST_EMIT: begin
                if (can_emit) state_next = mer_pkg::ST_IDLE;
            end
            default: state_next = mer_pkg::ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        cmd             = '0;
        cmd.mul_sel     = mer_pkg::MUL_RXRX;
        cmd.wr_sel      = mer_pkg::WR_NONE;
        cmd.emit_points = pts_reg;
        cmd.emit_done   = (phase_reg == mer_pkg::PH_DONE);
        unique case (state_reg)
            mer_pkg::ST_IDLE: cmd.load = accept && (s_op == mer_pkg::OP_START);
            mer_pkg::ST_SQ_RX: cmd.mul_sel = mer_pkg::MUL_RXRX;
            mer_pkg::ST_SQ_RY: begin
                cmd.wr_sel  = mer_pkg::WR_RX2;
                cmd.mul_sel = mer_pkg::MUL_RYRY;
            end
            mer_pkg::ST_INIT_MUL: begin
                cmd.wr_sel  = mer_pkg::WR_RY2;
                cmd.mul_sel = mer_pkg::MUL_RX2RY;
            end
            mer_pkg::ST_INIT_WR: cmd.wr_sel = mer_pkg::WR_INIT;
            mer_pkg::ST_TX_SQ:   cmd.mul_sel = mer_pkg::MUL_TXTX;
            mer_pkg::ST_RY2_T:   cmd.mul_sel = mer_pkg::MUL_RY2P;
            mer_pkg::ST_TY_SQ: begin
                cmd.wr_sel  = mer_pkg::WR_DEC_SET;
                cmd.mul_sel = mer_pkg::MUL_TYTY;
            end
            mer_pkg::ST_RX2_U: cmd.mul_sel = mer_pkg::MUL_RX2P;
            mer_pkg::ST_RX2_RY2: begin
                cmd.wr_sel  = mer_pkg::WR_DEC_ADD4;
                cmd.mul_sel = mer_pkg::MUL_RX2RY2;
            end
            mer_pkg::ST_DEC_FIX: cmd.wr_sel = mer_pkg::WR_DEC_SUB4;
            mer_pkg::ST_R1_STEP: cmd.r1_move = 1'b1;
            mer_pkg::ST_R2_STEP: cmd.r2_move = 1'b1;
            mer_pkg::ST_DEC_UPD: cmd.dec_upd = 1'b1;
            mer_pkg::ST_EMIT:    cmd.emit = can_emit;
            default: ;
        endcase
    end

    // ellipse phase, item kind and result valid
    always_comb begin
        phase_next   = phase_reg;
        pts_next     = pts_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (accept) begin
            if (s_op == mer_pkg::OP_START) begin
                phase_next = mer_pkg::PH_REG1;
                pts_next   = 1'b1;
            end else begin
                pts_next = (phase_reg == mer_pkg::PH_REG1) || (phase_reg == mer_pkg::PH_REG2);
            end
        end
        if (state_reg == mer_pkg::ST_DEC_FIX) begin
            phase_next = mer_pkg::PH_REG2;
        end
        if (state_reg == mer_pkg::ST_EMIT && can_emit) begin
            m_valid_next = 1'b1;
            if (pts_reg && status.y_zero) phase_next = mer_pkg::PH_DONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mer_pkg::ST_IDLE;
            phase_reg   <= mer_pkg::PH_IDLE;
            pts_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            pts_reg     <= pts_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

>>> hdl/midpoint_ellipse_rasterizer.sv
// top level of the midpoint ellipse rasterizer: controller plus datapath
//
//  channel | direction | payload                                       | handshake
//  s_      | in        | op, center_x, center_y, radius_x, radius_y    | s_valid / s_ready
//  m_      | out       | right_x, left_x, lower_y, upper_y,            | m_valid / m_ready
//          |           | points_valid, done_res                        |
//
// one item at a time: a start item runs three squarings/products on the shared
// multiplier, a plain step moves the point, updates the decision and emits, the
// step that switches to region two first runs five products for the new decision
// value, and a step with no ellipse running only emits its answer
// aresetn is synchronous and active low; it clears the sequencer, the phase and m_valid
// the result sits in an output register, so the next item is taken while
// a result still waits on m_ready; a held result only stalls the next emit
module midpoint_ellipse_rasterizer (
    input  logic                               aclk,
    input  logic                               aresetn,
    // item input channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [mer_pkg::OP_BITS-1:0]        s_op,
    input  logic [mer_pkg::COORD_BITS-1:0]     s_center_x,
    input  logic [mer_pkg::COORD_BITS-1:0]     s_center_y,
    input  logic [mer_pkg::COORD_BITS-1:0]     s_radius_x,
    input  logic [mer_pkg::COORD_BITS-1:0]     s_radius_y,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [mer_pkg::OUT_W-1:0]   m_right_x,
    output logic signed [mer_pkg::OUT_W-1:0]   m_left_x,
    output logic signed [mer_pkg::OUT_W-1:0]   m_lower_y,
    output logic signed [mer_pkg::OUT_W-1:0]   m_upper_y,
    output logic                               m_points_valid,
    output logic                               m_done_res
);

    // command and status between sequencer and datapath
    mer_pkg::dp_cmd_t    cmd;
    mer_pkg::dp_status_t status;

    // sequencer: decodes op against the phase, steps the multiplier schedule
    mer_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // datapath: offsets, slope terms, 64-bit decision value, mirrored points
    mer_dp u_dp (
        .aclk             (aclk),
        .cmd              (cmd),
        .status           (status),
        .in_center_x      (s_center_x),
        .in_center_y      (s_center_y),
        .in_radius_x      (s_radius_x),
        .in_radius_y      (s_radius_y),
        .out_right_x      (m_right_x),
        .out_left_x       (m_left_x),
        .out_lower_y      (m_lower_y),
        .out_upper_y      (m_upper_y),
        .out_points_valid (m_points_valid),
        .out_done_res     (m_done_res)
    );

endmodule

>>> sim/midpoint_ellipse_rasterizer_tb.sv
// testbench of the midpoint ellipse rasterizer: random handshakes, point-by-point prediction
`timescale 1ns / 100ps

module midpoint_ellipse_rasterizer_tb;

    localparam int RANDOM_ITEMS = 1800;
    localparam int HOLD_AT_ITEM = 400;   // item count that triggers the long receiver hold-off
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 2000;  // cycles with no handshake on either side
    localparam int DRAIN_CYCLES = 24;    // tail of the run, with m_ready held high

    // one input item as seen on the s_ channel
    typedef struct packed {
        logic [mer_pkg::OP_BITS-1:0]    op;
        logic [mer_pkg::COORD_BITS-1:0] center_x;
        logic [mer_pkg::COORD_BITS-1:0] center_y;
        logic [mer_pkg::COORD_BITS-1:0] radius_x;
        logic [mer_pkg::COORD_BITS-1:0] radius_y;
    } item_t;

    // one result item as seen on the m_ channel
    typedef struct packed {
        logic signed [mer_pkg::OUT_W-1:0] right_x;
        logic signed [mer_pkg::OUT_W-1:0] left_x;
        logic signed [mer_pkg::OUT_W-1:0] lower_y;
        logic signed [mer_pkg::OUT_W-1:0] upper_y;
        logic                             points_valid;
        logic                             done_res;
    } point_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // block ports, the inputs known from time zero
    logic                             s_valid    = 1'b0;
    logic                             s_ready;
    logic [mer_pkg::OP_BITS-1:0]      s_op       = mer_pkg::OP_START;
    logic [mer_pkg::COORD_BITS-1:0]   s_center_x = '0;
    logic [mer_pkg::COORD_BITS-1:0]   s_center_y = '0;
    logic [mer_pkg::COORD_BITS-1:0]   s_radius_x = '0;
    logic [mer_pkg::COORD_BITS-1:0]   s_radius_y = '0;
    logic                             m_valid;
    logic                             m_ready    = 1'b0;
    logic signed [mer_pkg::OUT_W-1:0] m_right_x;
    logic signed [mer_pkg::OUT_W-1:0] m_left_x;
    logic signed [mer_pkg::OUT_W-1:0] m_lower_y;
    logic signed [mer_pkg::OUT_W-1:0] m_upper_y;
    logic                             m_points_valid;
    logic                             m_done_res;

    midpoint_ellipse_rasterizer u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_center_x     (s_center_x),
        .s_center_y     (s_center_y),
        .s_radius_x     (s_radius_x),
        .s_radius_y     (s_radius_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_right_x      (m_right_x),
        .m_left_x       (m_left_x),
        .m_lower_y      (m_lower_y),
        .m_upper_y      (m_upper_y),
        .m_points_valid (m_points_valid),
        .m_done_res     (m_done_res)
    );

    // items waiting to be sent, and points the block still owes us
    item_t  pending_items[$];
    point_t expected_points[$];

    int mismatches  = 0;
    int items_taken = 0;
    int points_seen = 0;

    // ------------------------------------------------------------------
    // tracer state: a software copy of the ellipse walk
    // the decision value is kept at four times the textbook value so it
    // stays integral; everything wraps at 64 bits like the hardware decision
    // ------------------------------------------------------------------
    mer_pkg::phase_t                trace_phase = mer_pkg::PH_IDLE;
    logic [mer_pkg::COORD_BITS-1:0] cur_x       = '0;
    logic [mer_pkg::COORD_BITS-1:0] cur_y       = '0;
    logic [mer_pkg::COORD_BITS-1:0] org_x       = '0;
    logic [mer_pkg::COORD_BITS-1:0] org_y       = '0;
    logic [63:0]                    decision_q4 = '0;
    logic [63:0]                    slope_x     = '0;  // 2*ry^2*x
    logic [63:0]                    slope_y     = '0;  // 2*rx^2*y
    logic [63:0]                    rx_sq       = '0;
    logic [63:0]                    ry_sq       = '0;

    // advance the tracer by one item and return the point it answers with
    function automatic point_t trace_point(input item_t it);
        point_t      p;
        logic [63:0] ry64;
        logic [63:0] tx;
        logic [63:0] ty;
        p    = '0;
        ry64 = 64'(it.radius_y);
        if (it.op == mer_pkg::OP_START) begin
            // a start always wins, even over a walk that is still running
            org_x       = it.center_x;
            org_y       = it.center_y;
            rx_sq       = 64'(it.radius_x) * 64'(it.radius_x);
            ry_sq       = ry64 * ry64;
            cur_x       = '0;
            cur_y       = it.radius_y;
            slope_x     = '0;
            slope_y     = 64'd2 * rx_sq * ry64;
            decision_q4 = 64'd4 * ry_sq - 64'd4 * rx_sq * ry64 + rx_sq;
            // flat ellipse: the first point is also the last
            trace_phase = (it.radius_y == '0) ? mer_pkg::PH_DONE : mer_pkg::PH_REG1;
        end else if (trace_phase == mer_pkg::PH_IDLE) begin
            // nothing started yet: empty answer, state untouched
            return p;
        end else if (trace_phase == mer_pkg::PH_DONE) begin
            p.done_res = 1'b1;
            return p;
        end else begin
            if (trace_phase == mer_pkg::PH_REG1 && slope_x < slope_y) begin
                // region one: x always moves, y only on a non-negative decision
                cur_x   = cur_x + 1'b1;
                slope_x = slope_x + 64'd2 * ry_sq;
                if (decision_q4[63]) begin
                    decision_q4 = decision_q4 + 64'd4 * (slope_x + ry_sq);
                end else begin
                    cur_y       = cur_y - 1'b1;
                    slope_y     = slope_y - 64'd2 * rx_sq;
                    decision_q4 = decision_q4 + 64'd4 * (slope_x - slope_y + ry_sq);
                end
            end else begin
                if (trace_phase == mer_pkg::PH_REG1) begin
                    // slope crossed: reseed the decision for region two
                    tx          = 64'd2 * 64'(cur_x) + 64'd1;
                    ty          = 64'(cur_y) - 64'd1;
                    decision_q4 = ry_sq * tx * tx + 64'd4 * rx_sq * ty * ty
                                - 64'd4 * rx_sq * ry_sq;
                    trace_phase = mer_pkg::PH_REG2;
                end
                // region two: y always moves, x only on a zero or negative decision
                cur_y   = cur_y - 1'b1;
                slope_y = slope_y - 64'd2 * rx_sq;
                if (decision_q4 != 64'd0 && !decision_q4[63]) begin
                    decision_q4 = decision_q4 + 64'd4 * (rx_sq - slope_y);
                end else begin
                    cur_x       = cur_x + 1'b1;
                    slope_x     = slope_x + 64'd2 * ry_sq;
                    decision_q4 = decision_q4 + 64'd4 * (slope_x - slope_y + rx_sq);
                end
            end
            if (cur_y == '0)
                trace_phase = mer_pkg::PH_DONE;
        end
        // four mirrored points, wrapped to the output width
        p.right_x      = mer_pkg::OUT_W'(org_x) + mer_pkg::OUT_W'(cur_x);
        p.left_x       = mer_pkg::OUT_W'(org_x) - mer_pkg::OUT_W'(cur_x);
        p.lower_y      = mer_pkg::OUT_W'(org_y) + mer_pkg::OUT_W'(cur_y);
        p.upper_y      = mer_pkg::OUT_W'(org_y) - mer_pkg::OUT_W'(cur_y);
        p.points_valid = 1'b1;
        p.done_res     = (cur_y == '0);
        return p;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] point %0d: %s", $realtime, points_seen, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------
    task automatic add_item(input logic [mer_pkg::OP_BITS-1:0] op,
                            input logic [mer_pkg::COORD_BITS-1:0] cx,
                            input logic [mer_pkg::COORD_BITS-1:0] cy,
                            input logic [mer_pkg::COORD_BITS-1:0] rx,
                            input logic [mer_pkg::COORD_BITS-1:0] ry);
        item_t it;
        it.op       = op;
        it.center_x = cx;
        it.center_y = cy;
        it.radius_x = rx;
        it.radius_y = ry;
        pending_items.push_back(it);
    endtask

    // step items carry random junk in the fields the block ignores
    task automatic add_steps(input int n);
        for (int i = 0; i < n; i++)
            add_item(mer_pkg::OP_STEP,
                     mer_pkg::COORD_BITS'($urandom()), mer_pkg::COORD_BITS'($urandom()),
                     mer_pkg::COORD_BITS'($urandom()), mer_pkg::COORD_BITS'($urandom()));
    endtask

    // mostly small radii so walks finish, some medium, a few full-range
    function automatic logic [mer_pkg::COORD_BITS-1:0] pick_radius();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 78)
            return mer_pkg::COORD_BITS'($urandom_range(0, 20));
        else if (roll < 92)
            return mer_pkg::COORD_BITS'($urandom_range(21, 300));
        else
            return mer_pkg::COORD_BITS'($urandom());
    endfunction

    // ------------------------------------------------------------------
    // driver: bursts of items with random gaps, fed from pending_items
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_points.push_back(trace_point({s_op, s_center_x, s_center_y,
                                                       s_radius_x, s_radius_y}));
                items_taken <= items_taken + 1;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    item_t nxt;
                    nxt = pending_items.pop_front();
                    s_op       <= nxt.op;
                    s_center_x <= nxt.center_x;
                    s_center_y <= nxt.center_y;
                    s_radius_x <= nxt.radius_x;
                    s_radius_y <= nxt.radius_y;
                    s_valid    <= 1'b1;
                    if (burst_left <= 1) begin
                        // now and then a long burst with no gap at all
                        if ($urandom_range(0, 5) == 0) begin
                            burst_left = $urandom_range(60, 150);
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(1, 12);
                            gap_left   = $urandom_range(1, 9);
                        end
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // long receiver hold-off: the block has to fill up and push back
    // ------------------------------------------------------------------
    logic hold_off    = 1'b0;
    logic hold_used   = 1'b0;
    int   hold_cycles = 0;

    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            if (hold_cycles == 1)
                hold_off <= 1'b0;
        end else if (!hold_used && items_taken >= HOLD_AT_ITEM) begin
            hold_used   <= 1'b1;
            hold_off    <= 1'b1;
            hold_cycles <= HOLD_CYCLES;
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each result item and drives m_ready on a pattern of random modes
    // ------------------------------------------------------------------
    logic       draining     = 1'b0;
    int         rx_mode      = 0;
    int         rx_mode_left = 0;
    logic [2:0] rx_tick      = '0;
    logic       ready_next;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_points.size() == 0) begin
                    report_mismatch($sformatf("result with no item pending (%0d %0d %0d %0d)",
                                              m_right_x, m_left_x, m_lower_y, m_upper_y));
                end else begin
                    point_t want;
                    want = expected_points.pop_front();
                    if (m_right_x !== want.right_x)
                        report_mismatch($sformatf("right_x %0d, expected %0d",
                                                  m_right_x, want.right_x));
                    if (m_left_x !== want.left_x)
                        report_mismatch($sformatf("left_x %0d, expected %0d",
                                                  m_left_x, want.left_x));
                    if (m_lower_y !== want.lower_y)
                        report_mismatch($sformatf("lower_y %0d, expected %0d",
                                                  m_lower_y, want.lower_y));
                    if (m_upper_y !== want.upper_y)
                        report_mismatch($sformatf("upper_y %0d, expected %0d",
                                                  m_upper_y, want.upper_y));
                    if (m_points_valid !== want.points_valid)
                        report_mismatch($sformatf("points_valid %b, expected %b",
                                                  m_points_valid, want.points_valid));
                    if (m_done_res !== want.done_res)
                        report_mismatch($sformatf("done_res %b, expected %b",
                                                  m_done_res, want.done_res));
                end
                points_seen++;
            end

            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(20, 200);
            end else begin
                rx_mode_left--;
            end
            rx_tick = rx_tick + 1'b1;
            case (rx_mode)
                0:       ready_next = 1'b1;                        // no stalls
                1:       ready_next = 1'($urandom_range(0, 1));    // coin flip
                2:       ready_next = ($urandom_range(0, 4) == 0); // mostly stalled
                default: ready_next = (rx_tick != 3'b111);         // stall on every all-ones tick
            endcase
            m_ready <= draining || (!hold_off && ready_next);
        end
    end

    // ------------------------------------------------------------------
    // watchdog: ends the run when no item moves on either side for too long
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus plan, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        int                             total;
        int                             steps;
        logic [mer_pkg::COORD_BITS-1:0] rx;
        logic [mer_pkg::COORD_BITS-1:0] ry;

        // steps with nothing started: all fields low, then all high
        add_item(mer_pkg::OP_STEP, '0, '0, '0, '0);
        add_item(mer_pkg::OP_STEP, '1, '1, '1, '1);
        // both radii zero: the start answers done, the step after stays done
        add_item(mer_pkg::OP_START, '0, '0, '0, '0);
        add_steps(1);
        // zero vertical radius at the far corner
        add_item(mer_pkg::OP_START, '1, '1, '1, '0);
        add_steps(1);
        // zero horizontal radius: region two only, x stays at the center
        add_item(mer_pkg::OP_START, '0, '1, '0, 12'd3);
        add_steps(4);
        // small ellipse at the edge, points wrap below zero, runs past done
        add_item(mer_pkg::OP_START, '1, '0, 12'd4, 12'd2);
        add_steps(6);
        // largest radii, then a new start drops that walk part way
        add_item(mer_pkg::OP_START, 12'd2048, 12'd2048, '1, '1);
        add_steps(3);
        add_item(mer_pkg::OP_START, 12'd1, 12'd4094, 12'd2, 12'd1);
        add_steps(2);

        // random part: mostly whole walks with random content, some noise
        total = pending_items.size() + RANDOM_ITEMS;
        while (pending_items.size() < total) begin
            if ($urandom_range(0, 99) < 15) begin
                // noise: stray steps, or a start with no walk after it
                if ($urandom_range(0, 1) == 0)
                    add_steps($urandom_range(1, 4));
                else
                    add_item(mer_pkg::OP_START, mer_pkg::COORD_BITS'($urandom()),
                             mer_pkg::COORD_BITS'($urandom()), pick_radius(), pick_radius());
            end else begin
                rx = pick_radius();
                ry = pick_radius();
                add_item(mer_pkg::OP_START, mer_pkg::COORD_BITS'($urandom()),
                         mer_pkg::COORD_BITS'($urandom()), rx, ry);
                if (rx <= 40 && ry <= 40) begin
                    // enough steps to reach done and a few beyond
                    steps = int'(rx) + int'(ry) + $urandom_range(0, 3);
                    if ($urandom_range(0, 4) == 0)
                        steps = $urandom_range(0, steps);  // cut short by the next start
                end else begin
                    steps = $urandom_range(1, 40);
                end
                add_steps(steps);
            end
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // sample at the falling edge so the driver and monitor have settled
        do
            @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || expected_points.size() != 0);
        draining <= 1'b1;
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
